// File: rtl/tcw_pkg.sv
// Shared types and constants of the text console character writer.
`default_nettype none

package tcw_pkg;

   // Field widths fixed by the interface.
   localparam int OP_W      = 2;
   localparam int CHAR_W    = 8;
   localparam int ROW_W     = 5;
   localparam int COL_W     = 7;
   localparam int POS_W     = 11;
   localparam int WORD_W    = 16;
   localparam int ATTR_W    = 8;
   localparam int CSR_IDX_W = 1;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
   localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
   localparam logic [OP_W-1:0] OP_READ  = 2'd2;

   // Control characters and the blank character.
   localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
   localparam logic [CHAR_W-1:0] CH_LF    = 8'd10;
   localparam logic [CHAR_W-1:0] CH_CR    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_SPACE = 8'd32;

   // Register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_FILL_ATTR = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_TEXT_ATTR = 1'b1;
   localparam logic [ATTR_W-1:0]    FILL_ATTR_RESET = 8'd63;
   localparam logic [ATTR_W-1:0]    TEXT_ATTR_RESET = 8'd31;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PUT,
      ST_COPY,
      ST_FILL,
      ST_READ,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// File: rtl/tcw_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output logic      [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// File: rtl/text_console_char_writer.sv
// Sequence: a printable character, tab, CR or LF passes through the put and finishing states, a
// cell read through the read and finishing states, and an unused code straight to finishing; a put
// that scrolls adds a copy sweep and a bottom-row fill, and a clear adds a fill of the whole screen.
// Flow: one item at a time; the next request is taken once the result is placed in the output
// register, and the finishing state holds while that register still holds an earlier result.
// Reset: cursor at home, attributes at their defaults; screen contents undefined until written.
`default_nettype none

module text_console_char_writer #(
   parameter int SCREEN_COLS = 80,
   parameter int SCREEN_ROWS = 25,
   parameter int TAB_STOP    = 8
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Request channel.
   input  wire logic                                req_valid,
   output logic                                     req_stall,
   input  wire logic [tcw_pkg::OP_W-1:0]            req_operation,
   input  wire logic [tcw_pkg::CHAR_W-1:0]          req_char_code,
   input  wire logic [tcw_pkg::ROW_W-1:0]           req_read_row,
   input  wire logic [tcw_pkg::COL_W-1:0]           req_read_col,
   // Response channel.
   output logic                                     rsp_valid,
   input  wire logic                                rsp_stall,
   output logic      [tcw_pkg::POS_W-1:0]           rsp_cursor_position,
   output logic      [tcw_pkg::WORD_W-1:0]          rsp_cell_word,
   // Register write channel.
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [tcw_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [tcw_pkg::ATTR_W-1:0]          csr_wdata
);

   // The screen is kept row by row in one RAM; a cell's address is row * COLS + column.
   localparam int CELLS    = SCREEN_COLS * SCREEN_ROWS;
   localparam int AW       = $clog2(CELLS);
   localparam int PW       = $clog2(TAB_STOP);
   localparam int COPY_LEN = (SCREEN_ROWS - 1) * SCREEN_COLS;
   localparam int CWW      = tcw_pkg::COL_W + 1;
   localparam int RWW      = tcw_pkg::ROW_W + 1;
   localparam int PFW      = tcw_pkg::ROW_W + tcw_pkg::COL_W;

   localparam logic [AW-1:0]             COLS_A    = AW'(SCREEN_COLS);
   localparam logic [AW-1:0]             LAST_CELL = AW'(CELLS - 1);
   localparam logic [AW-1:0]             COPY_END  = AW'(COPY_LEN);
   localparam logic [CWW-1:0]            COLS_W    = CWW'(SCREEN_COLS);
   localparam logic [CWW-1:0]            TAB_W     = CWW'(TAB_STOP);
   localparam logic [RWW-1:0]            ROWS_W    = RWW'(SCREEN_ROWS);
   localparam logic [tcw_pkg::ROW_W-1:0] ROW_LAST  = tcw_pkg::ROW_W'(SCREEN_ROWS - 1);
   localparam logic [PW-1:0]             PH_LAST   = PW'(TAB_STOP - 1);
   localparam logic [PFW-1:0]            COLS_P    = PFW'(SCREEN_COLS);

   tcw_pkg::state_type state_ff, state_in;

   // Cursor, plus the column's place within its tab stop so that a tab needs no division.
   logic [tcw_pkg::COL_W-1:0]  col_ff, col_in;
   logic [tcw_pkg::ROW_W-1:0]  row_ff, row_in;
   logic [PW-1:0]              phase_ff, phase_in;

   // Sweep counter for scroll and clear, and the pending write-back of the scroll copy.
   logic [AW-1:0]              cnt_ff, cnt_in;
   logic                       wb_valid_ff, wb_valid_in;
   logic [AW-1:0]              wb_addr_ff, wb_addr_in;

   // Request held for the duration of the item.
   logic [tcw_pkg::CHAR_W-1:0] char_ff, char_in;
   logic [tcw_pkg::ROW_W-1:0]  read_row_ff, read_row_in;
   logic [tcw_pkg::COL_W-1:0]  read_col_ff, read_col_in;
   logic                       cell_ok_ff, cell_ok_in;

   logic [tcw_pkg::ATTR_W-1:0] fill_attr_ff, fill_attr_in;
   logic [tcw_pkg::ATTR_W-1:0] text_attr_ff, text_attr_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [tcw_pkg::POS_W-1:0]  rsp_pos_ff, rsp_pos_in;
   logic [tcw_pkg::WORD_W-1:0] rsp_word_ff, rsp_word_in;

   logic                       ram_wr_en;
   logic [AW-1:0]              ram_wr_addr;
   logic [tcw_pkg::WORD_W-1:0] ram_wr_data;
   logic                       ram_rd_en;
   logic [AW-1:0]              ram_rd_addr;
   logic [tcw_pkg::WORD_W-1:0] ram_rd_data;

   logic [AW-1:0]              cur_addr;
   logic [AW-1:0]              cell_addr;
   logic [PFW-1:0]             pos_full;
   logic [CWW-1:0]             col_wide;
   logic [RWW-1:0]             row_wide;
   logic [PW-1:0]              phase_next;
   logic [tcw_pkg::WORD_W-1:0] blank_word;

   tcw_ram #(
      .WIDTH (tcw_pkg::WORD_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   // Addresses and the reported position all come straight from registers.
   assign cur_addr   = AW'(row_ff) * COLS_A + AW'(col_ff);
   assign cell_addr  = AW'(read_row_ff) * COLS_A + AW'(read_col_ff);
   assign pos_full   = PFW'(row_ff) * COLS_P + PFW'(col_ff);
   assign blank_word = {fill_attr_ff, tcw_pkg::CH_SPACE};

   // The block takes a request only when it has nothing in hand.
   assign req_stall = (state_ff != tcw_pkg::ST_IDLE);

   // The user must write registers only while the block is idle; the block does not enforce it.
   assign csr_ready = 1'b1;

   always_comb begin
      fill_attr_in = fill_attr_ff;
      text_attr_in = text_attr_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            tcw_pkg::CSR_FILL_ATTR: fill_attr_in = csr_wdata;
            tcw_pkg::CSR_TEXT_ATTR: text_attr_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in    = state_ff;
      col_in      = col_ff;
      row_in      = row_ff;
      phase_in    = phase_ff;
      cnt_in      = cnt_ff;
      wb_valid_in = 1'b0;
      wb_addr_in  = wb_addr_ff;
      char_in     = char_ff;
      read_row_in = read_row_ff;
      read_col_in = read_col_ff;
      cell_ok_in  = cell_ok_ff;

      // The output register empties whenever its transfer completes.
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_pos_in   = rsp_pos_ff;
      rsp_word_in  = rsp_word_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = cur_addr;
      ram_wr_data = {text_attr_ff, char_ff};
      ram_rd_en   = 1'b0;
      ram_rd_addr = cell_addr;

      col_wide   = {1'b0, col_ff};
      row_wide   = {1'b0, row_ff};
      phase_next = phase_ff;

      case (state_ff)
         tcw_pkg::ST_IDLE: begin
            if (req_valid) begin
               char_in     = req_char_code;
               read_row_in = req_read_row;
               read_col_in = req_read_col;
               cell_ok_in  = 1'b0;
               case (req_operation)
                  tcw_pkg::OP_PUT: begin
                     state_in = tcw_pkg::ST_PUT;
                  end
                  tcw_pkg::OP_CLEAR: begin
                     col_in   = '0;
                     row_in   = '0;
                     phase_in = '0;
                     cnt_in   = '0;
                     state_in = tcw_pkg::ST_FILL;
                  end
                  tcw_pkg::OP_READ: begin
                     // A cell outside the screen reads as zero and touches nothing.
                     cell_ok_in = ({1'b0, req_read_row} < ROWS_W) &&
                                  ({1'b0, req_read_col} < COLS_W);
                     state_in   = tcw_pkg::ST_READ;
                  end
                  default: begin
                     state_in = tcw_pkg::ST_DONE;
                  end
               endcase
            end
         end

         tcw_pkg::ST_PUT: begin
            case (char_ff)
               tcw_pkg::CH_TAB: begin
                  col_wide   = {1'b0, col_ff} + (TAB_W - CWW'(phase_ff));
                  phase_next = '0;
               end
               tcw_pkg::CH_CR: begin
                  col_wide   = '0;
                  phase_next = '0;
               end
               tcw_pkg::CH_LF: begin
                  col_wide   = '0;
                  phase_next = '0;
                  row_wide   = {1'b0, row_ff} + 1'b1;
               end
               default: begin
                  // A printable byte goes to the cell under the cursor.
                  ram_wr_en  = 1'b1;
                  col_wide   = {1'b0, col_ff} + 1'b1;
                  phase_next = (phase_ff == PH_LAST) ? '0 : phase_ff + 1'b1;
               end
            endcase
            // Running off the right-hand edge wraps to the start of the next line.
            if (col_wide >= COLS_W) begin
               col_wide   = '0;
               phase_next = '0;
               row_wide   = row_wide + 1'b1;
            end
            col_in   = col_wide[tcw_pkg::COL_W-1:0];
            phase_in = phase_next;
            // Running off the bottom scrolls the screen up and keeps the cursor on the last row.
            if (row_wide >= ROWS_W) begin
               row_in   = ROW_LAST;
               cnt_in   = '0;
               state_in = tcw_pkg::ST_COPY;
            end else begin
               row_in   = row_wide[tcw_pkg::ROW_W-1:0];
               state_in = tcw_pkg::ST_DONE;
            end
         end

         tcw_pkg::ST_COPY: begin
            // Each cycle reads the cell one row further down and writes back the word read in
            // the cycle before; the destination always trails the source by a full row.
            if (cnt_ff != COPY_END) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cnt_ff + COLS_A;
               wb_valid_in = 1'b1;
               wb_addr_in  = cnt_ff;
               cnt_in      = cnt_ff + 1'b1;
            end else begin
               state_in = tcw_pkg::ST_FILL;
            end
            if (wb_valid_ff) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = wb_addr_ff;
               ram_wr_data = ram_rd_data;
            end
         end

         tcw_pkg::ST_FILL: begin
            // Blanks from the counter to the last cell: the bottom row after a scroll, or the
            // whole screen for a clear.
            ram_wr_en   = 1'b1;
            ram_wr_addr = cnt_ff;
            ram_wr_data = blank_word;
            if (cnt_ff == LAST_CELL) begin
               state_in = tcw_pkg::ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end

         tcw_pkg::ST_READ: begin
            ram_rd_en = cell_ok_ff;
            state_in  = tcw_pkg::ST_DONE;
         end

         tcw_pkg::ST_DONE: begin
            // The result waits here only while the output register still holds an earlier one.
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pos_in   = pos_full[tcw_pkg::POS_W-1:0];
               rsp_word_in  = cell_ok_ff ? ram_rd_data : '0;
               state_in     = tcw_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tcw_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tcw_pkg::ST_IDLE;
         col_ff       <= '0;
         row_ff       <= '0;
         phase_ff     <= '0;
         wb_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         fill_attr_ff <= tcw_pkg::FILL_ATTR_RESET;
         text_attr_ff <= tcw_pkg::TEXT_ATTR_RESET;
      end else begin
         state_ff     <= state_in;
         col_ff       <= col_in;
         row_ff       <= row_in;
         phase_ff     <= phase_in;
         wb_valid_ff  <= wb_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         fill_attr_ff <= fill_attr_in;
         text_attr_ff <= text_attr_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff      <= cnt_in;
      wb_addr_ff  <= wb_addr_in;
      char_ff     <= char_in;
      read_row_ff <= read_row_in;
      read_col_ff <= read_col_in;
      cell_ok_ff  <= cell_ok_in;
      rsp_pos_ff  <= rsp_pos_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_cursor_position = rsp_pos_ff;
   assign rsp_cell_word       = rsp_word_ff;

   // The cursor never leaves the screen.
   assert property (@(posedge clock) disable iff (reset)
      ({1'b0, col_ff} < COLS_W) && ({1'b0, row_ff} < ROWS_W))
      else $error("cursor outside the screen");

   // A result appears only as an item finishes.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == tcw_pkg::ST_DONE))
      else $error("result loaded outside the finishing state");

   // A request transfer always starts work.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != tcw_pkg::ST_IDLE))
      else $error("request taken but no work started");

   // Scroll write-backs belong to the copy sweep and land one row above the word's source.
   assert property (@(posedge clock) disable iff (reset)
      wb_valid_ff |-> (state_ff == tcw_pkg::ST_COPY) &&
                      (wb_addr_ff + COLS_A == $past(ram_rd_addr)))
      else $error("scroll write-back out of step with its read");

endmodule

`default_nettype wire
